FILE: hdl/pec_pkg.sv
// Shared types, widths and constants of the pretrigger episode capture block.
package pec_pkg;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  localparam int unsigned STAMP_W = 63;
  localparam int unsigned ANG_W = 32;
  localparam int unsigned THR_W = 31;
  localparam int unsigned SPEED_W = 24;
  localparam int unsigned DRIVE_W = 32;
  localparam int unsigned POS_W = 64;
  localparam int unsigned EPI_W = 32;
  localparam int unsigned SETTLE_W = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_TILT_TRIGGER = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RATE_TRIGGER = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_TILT_STABLE = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_RATE_STABLE = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TIME = CFG_IDX_W'(4);

  localparam logic [THR_W-1:0] TILT_TRIGGER_RST = THR_W'(1966);
  localparam logic [THR_W-1:0] RATE_TRIGGER_RST = THR_W'(3277);
  localparam logic [THR_W-1:0] TILT_STABLE_RST = THR_W'(655);
  localparam logic [THR_W-1:0] RATE_STABLE_RST = THR_W'(3277);
  localparam logic [SETTLE_W-1:0] SETTLE_TIME_RST = SETTLE_W'(500000000);

  localparam logic signed [POS_W-1:0] POS_LIMIT = {1'b0, {(POS_W - 1){1'b1}}};

  typedef struct packed {
    logic [STAMP_W-1:0]        stamp_ns;
    logic signed [ANG_W-1:0]   tilt;
    logic signed [ANG_W-1:0]   tilt_rate;
    logic signed [SPEED_W-1:0] speed;
    logic signed [DRIVE_W-1:0] drive;
  } sample_t;

  typedef struct packed {
    logic [STAMP_W-1:0]        stamp_ns;
    logic signed [ANG_W-1:0]   tilt;
    logic signed [ANG_W-1:0]   tilt_rate;
    logic signed [POS_W-1:0]   position;
    logic signed [SPEED_W-1:0] speed;
    logic signed [DRIVE_W-1:0] drive;
  } entry_t;

  typedef struct packed {
    logic [STAMP_W-1:0]        out_stamp_ns;
    logic signed [ANG_W-1:0]   out_tilt;
    logic signed [ANG_W-1:0]   out_tilt_rate;
    logic signed [POS_W-1:0]   out_position;
    logic signed [SPEED_W-1:0] out_speed;
    logic signed [DRIVE_W-1:0] out_drive;
    logic [EPI_W-1:0]          episode;
    logic                      last;
  } result_t;

  typedef struct packed {
    logic             capture;
    logic             diff;
    logic             mul_lo;
    logic             mul_hi;
    logic             sat;
    logic             acc;
    logic             mem_we;
    logic [PTR_W-1:0] mem_waddr;
    logic             rd_en;
    logic [PTR_W-1:0] rd_addr;
    logic             trigger;
    logic             settle_upd;
    logic             settle_clr;
    logic             out_load;
    logic             out_sel_ring;
    logic             out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic trigger;
    logic settle_done;
  } dp_status_t;

endpackage

FILE: hdl/pec_ifs.sv
// Channel interfaces of the pretrigger episode capture block.
interface pec_in_if;
  logic                               valid;
  logic                               ready;
  logic [pec_pkg::STAMP_W-1:0]        stamp_ns;
  logic signed [pec_pkg::ANG_W-1:0]   tilt;
  logic signed [pec_pkg::ANG_W-1:0]   tilt_rate;
  logic signed [pec_pkg::SPEED_W-1:0] speed;
  logic signed [pec_pkg::DRIVE_W-1:0] drive;

  modport source (output valid, stamp_ns, tilt, tilt_rate, speed, drive, input ready);
  modport sink (input valid, stamp_ns, tilt, tilt_rate, speed, drive, output ready);
endinterface

interface pec_out_if;
  logic                               valid;
  logic                               ready;
  logic [pec_pkg::STAMP_W-1:0]        out_stamp_ns;
  logic signed [pec_pkg::ANG_W-1:0]   out_tilt;
  logic signed [pec_pkg::ANG_W-1:0]   out_tilt_rate;
  logic signed [pec_pkg::POS_W-1:0]   out_position;
  logic signed [pec_pkg::SPEED_W-1:0] out_speed;
  logic signed [pec_pkg::DRIVE_W-1:0] out_drive;
  logic [pec_pkg::EPI_W-1:0]          episode;
  logic                               last;

  modport source (output valid, out_stamp_ns, out_tilt, out_tilt_rate, out_position,
                  out_speed, out_drive, episode, last, input ready);
  modport sink (input valid, out_stamp_ns, out_tilt, out_tilt_rate, out_position,
                out_speed, out_drive, episode, last, output ready);
endinterface

interface pec_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [pec_pkg::CFG_IDX_W-1:0]    index;
  logic [pec_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/pec_dp.sv
// Datapath: configuration registers, position integrator, sample ring and result register.
module pec_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pec_pkg::dp_cmd_t                cmd_i,
  output pec_pkg::dp_status_t             status_o,
  input  pec_pkg::sample_t                sample_i,
  input  logic                            cfg_we_i,
  input  logic [pec_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [pec_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output pec_pkg::result_t                result_o
);

  localparam logic signed [pec_pkg::POS_W:0] SUM_MAX = {1'b0, pec_pkg::POS_LIMIT};
  localparam logic signed [pec_pkg::POS_W:0] SUM_MIN = -SUM_MAX;

  logic [pec_pkg::THR_W-1:0]    tilt_trig_q, rate_trig_q, tilt_stab_q, rate_stab_q;
  logic [pec_pkg::SETTLE_W-1:0] settle_time_q;

  pec_pkg::sample_t             smp_q;
  logic [pec_pkg::STAMP_W-1:0]  prev_q;
  logic [pec_pkg::STAMP_W-1:0]  absd_q;
  logic [pec_pkg::SPEED_W-1:0]  abss_q;
  logic                         negd_q, negs_q, integ_q, trig_q, stable_q;
  logic [55:0]                  plo_q;
  logic [54:0]                  phi_q;
  logic signed [pec_pkg::POS_W-1:0] p_q;
  logic signed [pec_pkg::POS_W-1:0] acc_q;
  logic [pec_pkg::EPI_W-1:0]    episode_q;
  logic [pec_pkg::STAMP_W-1:0]  settle_q;

  pec_pkg::entry_t              mem_q [pec_pkg::DEPTH];
  pec_pkg::entry_t              rd_q;
  pec_pkg::result_t             out_q;

  logic [pec_pkg::ANG_W-1:0]    tilt_u, rate_u, tilt_mag, rate_mag;
  logic [pec_pkg::SPEED_W-1:0]  speed_u;
  logic [86:0]                  prod_full;
  logic [pec_pkg::POS_W-2:0]    prod_mag;
  logic signed [pec_pkg::POS_W:0] sum;
  logic [pec_pkg::STAMP_W-1:0]  settle_gap;

  always_comb begin
    tilt_u = smp_q.tilt;
    rate_u = smp_q.tilt_rate;
    speed_u = smp_q.speed;
    tilt_mag = tilt_u[pec_pkg::ANG_W-1] ? (pec_pkg::ANG_W'(0) - tilt_u) : tilt_u;
    rate_mag = rate_u[pec_pkg::ANG_W-1] ? (pec_pkg::ANG_W'(0) - rate_u) : rate_u;
    prod_full = {phi_q, 32'b0} + 87'(plo_q);
    prod_mag = (|prod_full[86:63]) ? pec_pkg::POS_LIMIT[pec_pkg::POS_W-2:0]
                                   : prod_full[62:0];
    sum = {acc_q[pec_pkg::POS_W-1], acc_q} + {p_q[pec_pkg::POS_W-1], p_q};
    settle_gap = smp_q.stamp_ns - settle_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tilt_trig_q <= pec_pkg::TILT_TRIGGER_RST;
      rate_trig_q <= pec_pkg::RATE_TRIGGER_RST;
      tilt_stab_q <= pec_pkg::TILT_STABLE_RST;
      rate_stab_q <= pec_pkg::RATE_STABLE_RST;
      settle_time_q <= pec_pkg::SETTLE_TIME_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        pec_pkg::REG_TILT_TRIGGER: tilt_trig_q <= cfg_data_i[pec_pkg::THR_W-1:0];
        pec_pkg::REG_RATE_TRIGGER: rate_trig_q <= cfg_data_i[pec_pkg::THR_W-1:0];
        pec_pkg::REG_TILT_STABLE:  tilt_stab_q <= cfg_data_i[pec_pkg::THR_W-1:0];
        pec_pkg::REG_RATE_STABLE:  rate_stab_q <= cfg_data_i[pec_pkg::THR_W-1:0];
        pec_pkg::REG_SETTLE_TIME:  settle_time_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      smp_q <= sample_i;
    end
    if (cmd_i.diff) begin
      negd_q <= smp_q.stamp_ns < prev_q;
      absd_q <= (smp_q.stamp_ns < prev_q) ? (prev_q - smp_q.stamp_ns)
                                           : (smp_q.stamp_ns - prev_q);
      negs_q <= speed_u[pec_pkg::SPEED_W-1];
      abss_q <= speed_u[pec_pkg::SPEED_W-1] ? (pec_pkg::SPEED_W'(0) - speed_u) : speed_u;
      integ_q <= prev_q != '0;
      trig_q <= (tilt_mag > {1'b0, tilt_trig_q}) || (rate_mag > {1'b0, rate_trig_q});
      stable_q <= (tilt_mag < {1'b0, tilt_stab_q}) && (rate_mag < {1'b0, rate_stab_q});
    end
    if (cmd_i.mul_lo) begin
      plo_q <= 56'(absd_q[31:0]) * 56'(abss_q);
    end
    if (cmd_i.mul_hi) begin
      phi_q <= 55'(absd_q[62:32]) * 55'(abss_q);
    end
    if (cmd_i.sat) begin
      p_q <= (negd_q ^ negs_q) ? -$signed({1'b0, prod_mag}) : $signed({1'b0, prod_mag});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      acc_q <= '0;
      episode_q <= '0;
      settle_q <= '0;
    end else begin
      if (cmd_i.diff) begin
        prev_q <= smp_q.stamp_ns;
      end
      if (cmd_i.acc && integ_q) begin
        if (sum > SUM_MAX) begin
          acc_q <= pec_pkg::POS_LIMIT;
        end else if (sum < SUM_MIN) begin
          acc_q <= -pec_pkg::POS_LIMIT;
        end else begin
          acc_q <= sum[pec_pkg::POS_W-1:0];
        end
      end
      if (cmd_i.trigger) begin
        episode_q <= episode_q + 1'b1;
      end
      if (cmd_i.trigger || cmd_i.settle_clr) begin
        settle_q <= '0;
      end else if (cmd_i.settle_upd) begin
        if (!stable_q) begin
          settle_q <= '0;
        end else if (settle_q == '0) begin
          settle_q <= smp_q.stamp_ns;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) begin
      mem_q[cmd_i.mem_waddr] <= '{stamp_ns: smp_q.stamp_ns, tilt: smp_q.tilt,
                                  tilt_rate: smp_q.tilt_rate, position: acc_q,
                                  speed: smp_q.speed, drive: smp_q.drive};
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[cmd_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (cmd_i.out_sel_ring) begin
        out_q <= '{out_stamp_ns: rd_q.stamp_ns, out_tilt: rd_q.tilt,
                   out_tilt_rate: rd_q.tilt_rate, out_position: rd_q.position,
                   out_speed: rd_q.speed, out_drive: rd_q.drive,
                   episode: episode_q, last: cmd_i.out_last};
      end else begin
        out_q <= '{out_stamp_ns: smp_q.stamp_ns, out_tilt: smp_q.tilt,
                   out_tilt_rate: smp_q.tilt_rate, out_position: acc_q,
                   out_speed: smp_q.speed, out_drive: smp_q.drive,
                   episode: episode_q, last: cmd_i.out_last};
      end
    end
  end

  assign status_o.trigger = trig_q;
  assign status_o.settle_done = stable_q && (smp_q.stamp_ns >= settle_q)
                                && (settle_gap >= pec_pkg::STAMP_W'(settle_time_q));
  assign result_o = out_q;

endmodule

FILE: hdl/pec_ctrl.sv
// Controller: sequences one sample through the datapath and streams the ring out.
module pec_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  pec_pkg::dp_status_t   status_i,
  output pec_pkg::dp_cmd_t      cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DIFF   = 4'd1;
  localparam logic [3:0] S_MUL_LO = 4'd2;
  localparam logic [3:0] S_MUL_HI = 4'd3;
  localparam logic [3:0] S_SAT    = 4'd4;
  localparam logic [3:0] S_ACC    = 4'd5;
  localparam logic [3:0] S_DECIDE = 4'd6;
  localparam logic [3:0] S_EMIT   = 4'd7;
  localparam logic [3:0] S_SETTLE = 4'd8;
  localparam logic [3:0] S_DUMP   = 4'd9;

  localparam int unsigned EXT_W = pec_pkg::CNT_W + 1;

  logic [3:0]                  state_q, state_d;
  logic                        recording_q, recording_d;
  logic [pec_pkg::PTR_W-1:0]   head_q, head_d, rptr_q, rptr_d, head_n;
  logic [pec_pkg::CNT_W-1:0]   count_q, count_d, rem_q, rem_d, count_n;
  logic                        rdv_q, rdv_d, rdlast_q, rdlast_d;
  logic                        out_valid_q, out_valid_d;
  logic                        can_load, move, issue;
  logic [EXT_W-1:0]            head_x, count_x, start_x;

  always_comb begin
    head_n = (head_q == pec_pkg::PTR_LAST) ? '0 : head_q + 1'b1;
    count_n = (count_q == pec_pkg::CNT_FULL) ? count_q : count_q + 1'b1;
    head_x = EXT_W'(head_n);
    count_x = EXT_W'(count_n);
    start_x = (head_x >= count_x) ? (head_x - count_x)
                                  : (head_x + EXT_W'(pec_pkg::DEPTH) - count_x);
    can_load = !out_valid_q || out_ready_i;
    move = rdv_q && can_load;
    issue = (rem_q != '0) && (!rdv_q || move);
  end

  always_comb begin
    state_d = state_q;
    recording_d = recording_q;
    head_d = head_q;
    count_d = count_q;
    rptr_d = rptr_q;
    rem_d = rem_q;
    rdv_d = rdv_q;
    rdlast_d = rdlast_q;
    in_ready_o = 1'b0;
    cmd_o = '0;
    cmd_o.mem_waddr = head_q;
    cmd_o.rd_addr = rptr_q;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d = S_MUL_LO;
      end
      S_MUL_LO: begin
        cmd_o.mul_lo = 1'b1;
        state_d = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd_o.mul_hi = 1'b1;
        state_d = S_SAT;
      end
      S_SAT: begin
        cmd_o.sat = 1'b1;
        state_d = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (recording_q) begin
          state_d = S_EMIT;
        end else begin
          cmd_o.mem_we = 1'b1;
          if (status_i.trigger) begin
            cmd_o.trigger = 1'b1;
            recording_d = 1'b1;
            rptr_d = start_x[pec_pkg::PTR_W-1:0];
            rem_d = count_n;
            head_d = '0;
            count_d = '0;
            state_d = S_DUMP;
          end else begin
            head_d = head_n;
            count_d = count_n;
            state_d = S_IDLE;
          end
        end
      end
      S_EMIT: begin
        if (can_load) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = 1'b1;
          cmd_o.settle_upd = 1'b1;
          state_d = S_SETTLE;
        end
      end
      S_SETTLE: begin
        if (status_i.settle_done) begin
          cmd_o.settle_clr = 1'b1;
          recording_d = 1'b0;
          head_d = '0;
          count_d = '0;
        end
        state_d = S_IDLE;
      end
      S_DUMP: begin
        if (move) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel_ring = 1'b1;
          cmd_o.out_last = rdlast_q;
        end
        if (issue) begin
          cmd_o.rd_en = 1'b1;
          rptr_d = (rptr_q == pec_pkg::PTR_LAST) ? '0 : rptr_q + 1'b1;
          rem_d = rem_q - 1'b1;
          rdlast_d = rem_q == pec_pkg::CNT_W'(1);
          rdv_d = 1'b1;
        end else if (move) begin
          rdv_d = 1'b0;
        end
        if (move && (rem_q == '0)) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      recording_q <= 1'b0;
      head_q <= '0;
      count_q <= '0;
      rptr_q <= '0;
      rem_q <= '0;
      rdv_q <= 1'b0;
      rdlast_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      recording_q <= recording_d;
      head_q <= head_d;
      count_q <= count_d;
      rptr_q <= rptr_d;
      rem_q <= rem_d;
      rdv_q <= rdv_d;
      rdlast_q <= rdlast_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_dump_recording: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DUMP) |-> recording_q)
    else $error("ring dump running outside of an episode");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q <= pec_pkg::CNT_FULL) && (rem_q <= pec_pkg::CNT_FULL))
    else $error("ring fill count beyond depth");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while still pending");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (!rdv_q && (rem_q == '0)))
    else $error("dump left unfinished on return to idle");

endmodule

FILE: hdl/pretrigger_episode_capture.sv
// Top level of the pretrigger episode capture block.
// Each request on in_if is one timed sample; each request on out_if is one
// emitted sample with its integrated position, episode number and last flag.
// cfg_if writes the trigger and stability thresholds and the settle time; it
// is always ready and should be used only while the block is idle.
// A sample that causes no result passes through the six-step controller
// sequence around the 32 by 24 and 31 by 24 multiplies that form the
// position increment in halves.
// While an episode is recording, a sample also passes the emit and settle
// states, and its result is loaded into the output register in emit.
// A triggering sample is followed by the buffered ring, oldest first, one
// result per cycle from the ring memory read port while the receiver is
// ready, for up to 64 buffered samples.
// Reset clears the ring fill count, the episode counter, the integrator and
// loads the default thresholds; no memory clearing pass is needed.
// When the receiver stalls, the pending result holds in the output register;
// a ring dump pauses and takes no sample; otherwise a new sample is still
// accepted but waits for the output register before its result is loaded.
module pretrigger_episode_capture (
  input  logic       clk_i,
  input  logic       rst_ni,
  pec_in_if.sink     in_if,
  pec_out_if.source  out_if,
  pec_cfg_if.sink    cfg_if
);

  pec_pkg::dp_cmd_t    cmd;
  pec_pkg::dp_status_t status;
  pec_pkg::sample_t    sample;
  pec_pkg::result_t    result;

  assign sample = '{stamp_ns: in_if.stamp_ns, tilt: in_if.tilt, tilt_rate: in_if.tilt_rate,
                    speed: in_if.speed, drive: in_if.drive};

  assign cfg_if.ready = 1'b1;

  pec_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  pec_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .sample_i    (sample),
    .cfg_we_i    (cfg_if.valid),
    .cfg_index_i (cfg_if.index),
    .cfg_data_i  (cfg_if.data),
    .result_o    (result)
  );

  assign out_if.out_stamp_ns = result.out_stamp_ns;
  assign out_if.out_tilt = result.out_tilt;
  assign out_if.out_tilt_rate = result.out_tilt_rate;
  assign out_if.out_position = result.out_position;
  assign out_if.out_speed = result.out_speed;
  assign out_if.out_drive = result.out_drive;
  assign out_if.episode = result.episode;
  assign out_if.last = result.last;

endmodule

FILE: sim/pretrigger_episode_capture_chk.sv
// Checker that predicts and compares every result request of the capture block.
module pretrigger_episode_capture_chk (
  input  logic        clk_i,
  input  logic        rst_ni,
  pec_in_if           in_mon,
  pec_out_if          out_mon,
  pec_cfg_if          cfg_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o,
  output int unsigned episodes_o,
  output logic        recording_o
);

  localparam logic signed [pec_pkg::POS_W:0] SUM_MAX =
    {2'b00, {(pec_pkg::POS_W - 1){1'b1}}};

  pec_pkg::entry_t                  history [pec_pkg::DEPTH];
  logic [pec_pkg::PTR_W-1:0]        wr_ptr;
  logic [pec_pkg::CNT_W-1:0]        fill;
  logic                             capturing;
  logic [pec_pkg::EPI_W-1:0]        episode_num;
  logic [63:0]                      last_stamp;
  logic [63:0]                      calm_since;
  logic signed [pec_pkg::POS_W-1:0] position;
  logic [pec_pkg::THR_W-1:0]        tilt_trig, rate_trig, tilt_calm, rate_calm;
  logic [pec_pkg::SETTLE_W-1:0]     settle_ns;
  pec_pkg::result_t                 expected_q[$];
  int unsigned                      fails;
  int unsigned                      checked;

  function automatic logic [pec_pkg::ANG_W:0] magnitude(logic [pec_pkg::ANG_W-1:0] v);
    return v[pec_pkg::ANG_W-1] ? {1'b1, {pec_pkg::ANG_W{1'b0}}} - {1'b0, v} : {1'b0, v};
  endfunction

  function automatic logic signed [pec_pkg::POS_W-1:0] moved_position(
      logic signed [pec_pkg::POS_W-1:0] acc,
      logic [63:0] from_ns,
      logic [63:0] to_ns,
      logic [pec_pkg::SPEED_W-1:0] spd);
    logic                           back;
    logic [63:0]                    span;
    logic [63:0]                    spd_abs;
    logic [63:0]                    prod;
    logic signed [pec_pkg::POS_W:0] delta;
    logic signed [pec_pkg::POS_W:0] total;
    back = to_ns < from_ns;
    span = back ? from_ns - to_ns : to_ns - from_ns;
    spd_abs = spd[pec_pkg::SPEED_W-1]
              ? 64'({1'b1, {pec_pkg::SPEED_W{1'b0}}} - {1'b0, spd}) : 64'(spd);
    if (spd_abs != 0 && span > $unsigned(pec_pkg::POS_LIMIT) / spd_abs) begin
      prod = $unsigned(pec_pkg::POS_LIMIT);
    end else begin
      prod = span * spd_abs;
    end
    delta = (back != spd[pec_pkg::SPEED_W-1]) ? -$signed({1'b0, prod}) : $signed({1'b0, prod});
    total = $signed({acc[pec_pkg::POS_W-1], acc}) + delta;
    if (total > SUM_MAX) return pec_pkg::POS_LIMIT;
    if (total < -SUM_MAX) return -pec_pkg::POS_LIMIT;
    return total[pec_pkg::POS_W-1:0];
  endfunction

  function automatic pec_pkg::result_t as_result(pec_pkg::entry_t e,
                                                 logic [pec_pkg::EPI_W-1:0] epi, logic fin);
    return '{out_stamp_ns: e.stamp_ns, out_tilt: e.tilt, out_tilt_rate: e.tilt_rate,
             out_position: e.position, out_speed: e.speed, out_drive: e.drive,
             episode: epi, last: fin};
  endfunction

  task automatic take_sample(pec_pkg::sample_t s);
    pec_pkg::entry_t         e;
    logic [pec_pkg::ANG_W:0] tilt_mag;
    logic [pec_pkg::ANG_W:0] rate_mag;
    int unsigned             idx;
    tilt_mag = magnitude(s.tilt);
    rate_mag = magnitude(s.tilt_rate);
    if (last_stamp != 0) position = moved_position(position, last_stamp, {1'b0, s.stamp_ns},
                                                   s.speed);
    last_stamp = {1'b0, s.stamp_ns};
    e = '{stamp_ns: s.stamp_ns, tilt: s.tilt, tilt_rate: s.tilt_rate, position: position,
          speed: s.speed, drive: s.drive};
    if (!capturing) begin
      history[wr_ptr] = e;
      wr_ptr = (wr_ptr == pec_pkg::PTR_LAST) ? '0 : wr_ptr + 1'b1;
      if (fill != pec_pkg::CNT_FULL) fill = fill + 1'b1;
      if (tilt_mag > tilt_trig || rate_mag > rate_trig) begin
        capturing = 1'b1;
        episode_num = episode_num + 1'b1;
        calm_since = '0;
        idx = (int'(wr_ptr) + pec_pkg::DEPTH - int'(fill)) % pec_pkg::DEPTH;
        for (int i = 0; i < int'(fill); i++) begin
          expected_q.insert(expected_q.size(),
                            as_result(history[idx], episode_num, i == int'(fill) - 1));
          idx = (idx + 1) % pec_pkg::DEPTH;
        end
        fill = '0;
        wr_ptr = '0;
      end
    end else begin
      expected_q.insert(expected_q.size(), as_result(e, episode_num, 1'b1));
      if (tilt_mag < tilt_calm && rate_mag < rate_calm) begin
        if (calm_since == 0) calm_since = last_stamp;
        if (last_stamp >= calm_since && last_stamp - calm_since >= settle_ns) begin
          capturing = 1'b0;
          calm_since = '0;
          fill = '0;
          wr_ptr = '0;
        end
      end else begin
        calm_since = '0;
      end
    end
  endtask

  task automatic check_field(string what, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      fails++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pec_pkg::result_t got;
    pec_pkg::result_t want;
    if (!rst_ni) begin
      wr_ptr = '0;
      fill = '0;
      capturing = 1'b0;
      episode_num = '0;
      last_stamp = '0;
      calm_since = '0;
      position = '0;
      tilt_trig = pec_pkg::TILT_TRIGGER_RST;
      rate_trig = pec_pkg::RATE_TRIGGER_RST;
      tilt_calm = pec_pkg::TILT_STABLE_RST;
      rate_calm = pec_pkg::RATE_STABLE_RST;
      settle_ns = pec_pkg::SETTLE_TIME_RST;
      expected_q.delete();
      fails = 0;
      checked = 0;
      fail_count_o <= 0;
      pending_o <= 0;
      checked_o <= 0;
      episodes_o <= 0;
      recording_o <= 1'b0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          pec_pkg::REG_TILT_TRIGGER: tilt_trig = cfg_mon.data[pec_pkg::THR_W-1:0];
          pec_pkg::REG_RATE_TRIGGER: rate_trig = cfg_mon.data[pec_pkg::THR_W-1:0];
          pec_pkg::REG_TILT_STABLE:  tilt_calm = cfg_mon.data[pec_pkg::THR_W-1:0];
          pec_pkg::REG_RATE_STABLE:  rate_calm = cfg_mon.data[pec_pkg::THR_W-1:0];
          pec_pkg::REG_SETTLE_TIME:  settle_ns = cfg_mon.data[pec_pkg::SETTLE_W-1:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_stamp_ns: out_mon.out_stamp_ns, out_tilt: out_mon.out_tilt,
                out_tilt_rate: out_mon.out_tilt_rate, out_position: out_mon.out_position,
                out_speed: out_mon.out_speed, out_drive: out_mon.out_drive,
                episode: out_mon.episode, last: out_mon.last};
        if (expected_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result, expected none, got stamp %h episode %h",
                   $time, got.out_stamp_ns, got.episode);
        end else begin
          want = expected_q[0];
          expected_q.delete(0);
          checked++;
          check_field("stamp", want.out_stamp_ns, got.out_stamp_ns);
          check_field("tilt", want.out_tilt, got.out_tilt);
          check_field("tilt rate", want.out_tilt_rate, got.out_tilt_rate);
          check_field("position", want.out_position, got.out_position);
          check_field("speed", want.out_speed, got.out_speed);
          check_field("drive", want.out_drive, got.out_drive);
          check_field("episode", want.episode, got.episode);
          check_field("last", want.last, got.last);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        take_sample('{stamp_ns: in_mon.stamp_ns, tilt: in_mon.tilt,
                      tilt_rate: in_mon.tilt_rate, speed: in_mon.speed, drive: in_mon.drive});
      end
      fail_count_o <= fails;
      pending_o <= expected_q.size();
      checked_o <= checked;
      episodes_o <= episode_num;
      recording_o <= capturing;
    end
  end

endmodule

FILE: sim/pretrigger_episode_capture_tb.sv
// Testbench top that drives samples and register writes into the capture block.
module pretrigger_episode_capture_tb;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned DRAIN_CYCLES = 16;

  typedef enum logic [1:0] {SHAPE_QUIET, SHAPE_KICK, SHAPE_CALM, SHAPE_NOISE} shape_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  pec_in_if  sample_if();
  pec_out_if result_if();
  pec_cfg_if reg_if();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned episodes;
  logic        recording;

  int unsigned                  cycle_count = 0;
  int unsigned                  items_sent = 0;
  int unsigned                  reg_writes = 0;
  int unsigned                  burst_left = 0;
  int unsigned                  hold_left = 0;
  logic [pec_pkg::STAMP_W-1:0]  stamp_now = '0;
  logic [pec_pkg::THR_W-1:0]    trig_tilt = pec_pkg::TILT_TRIGGER_RST;
  logic [pec_pkg::THR_W-1:0]    trig_rate = pec_pkg::RATE_TRIGGER_RST;
  logic [pec_pkg::THR_W-1:0]    calm_tilt = pec_pkg::TILT_STABLE_RST;
  logic [pec_pkg::THR_W-1:0]    calm_rate = pec_pkg::RATE_STABLE_RST;
  logic [pec_pkg::SETTLE_W-1:0] settle_ns = pec_pkg::SETTLE_TIME_RST;

  pretrigger_episode_capture dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (sample_if),
    .out_if (result_if),
    .cfg_if (reg_if)
  );

  pretrigger_episode_capture_chk u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (sample_if),
    .out_mon      (result_if),
    .cfg_mon      (reg_if),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .episodes_o   (episodes),
    .recording_o  (recording)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles.", CYCLE_LIMIT);
      $display("pretrigger_episode_capture_tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    int unsigned roll;
    if (hold_left != 0) begin
      hold_left--;
    end else begin
      roll = $urandom_range(0, 3);
      if (roll == 0) begin
        result_if.ready <= 1'b1;
        hold_left = $urandom_range(30, 150);
      end else if (roll == 3) begin
        result_if.ready <= 1'b0;
        hold_left = $urandom_range(0, 7);
      end else begin
        result_if.ready <= 1'b1;
        hold_left = $urandom_range(0, 5);
      end
    end
  end

  task automatic send(logic [pec_pkg::STAMP_W-1:0] st, logic signed [pec_pkg::ANG_W-1:0] ti, ra,
                      logic signed [pec_pkg::SPEED_W-1:0] sp,
                      logic signed [pec_pkg::DRIVE_W-1:0] dr);
    int unsigned gap;
    stamp_now = st;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        sample_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    sample_if.valid <= 1'b1;
    sample_if.stamp_ns <= st;
    sample_if.tilt <= ti;
    sample_if.tilt_rate <= ra;
    sample_if.speed <= sp;
    sample_if.drive <= dr;
    do @(posedge clk_i); while (!sample_if.ready);
    items_sent++;
  endtask

  task automatic settle_down();
    sample_if.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [pec_pkg::CFG_IDX_W-1:0] idx,
                           logic [pec_pkg::CFG_DATA_W-1:0] val);
    reg_if.valid <= 1'b1;
    reg_if.index <= idx;
    reg_if.data <= val;
    do @(posedge clk_i); while (!reg_if.ready);
    reg_writes++;
  endtask

  task automatic apply_settings(logic [pec_pkg::CFG_DATA_W-1:0] t_trig, r_trig, t_calm, r_calm,
                                settle, bit stray);
    write_reg(pec_pkg::REG_TILT_TRIGGER, t_trig);
    write_reg(pec_pkg::REG_RATE_TRIGGER, r_trig);
    write_reg(pec_pkg::REG_TILT_STABLE, t_calm);
    write_reg(pec_pkg::REG_RATE_STABLE, r_calm);
    write_reg(pec_pkg::REG_SETTLE_TIME, settle);
    if (stray) begin
      for (int k = int'(pec_pkg::REG_SETTLE_TIME) + 1; k < (1 << pec_pkg::CFG_IDX_W); k++) begin
        write_reg(pec_pkg::CFG_IDX_W'(k), $urandom());
      end
    end
    reg_if.valid <= 1'b0;
    trig_tilt = t_trig[pec_pkg::THR_W-1:0];
    trig_rate = r_trig[pec_pkg::THR_W-1:0];
    calm_tilt = t_calm[pec_pkg::THR_W-1:0];
    calm_rate = r_calm[pec_pkg::THR_W-1:0];
    settle_ns = settle[pec_pkg::SETTLE_W-1:0];
  endtask

  function automatic logic signed [pec_pkg::ANG_W-1:0] either_sign(
      logic [pec_pkg::ANG_W-1:0] m);
    return $urandom_range(0, 1) ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [pec_pkg::ANG_W-1:0] angle_below(
      logic [pec_pkg::THR_W-1:0] lim);
    return either_sign($urandom_range(0, lim));
  endfunction

  function automatic logic signed [pec_pkg::ANG_W-1:0] angle_above(
      logic [pec_pkg::THR_W-1:0] lim);
    if (lim == '1 || $urandom_range(0, 15) == 0) return {1'b1, {(pec_pkg::ANG_W - 1){1'b0}}};
    return either_sign($urandom_range(lim + 1, {1'b0, {pec_pkg::THR_W{1'b1}}}));
  endfunction

  function automatic logic signed [pec_pkg::ANG_W-1:0] angle_calm(
      logic [pec_pkg::THR_W-1:0] lim);
    if (lim == '0) return '0;
    return either_sign($urandom_range(0, lim - 1));
  endfunction

  function automatic logic signed [pec_pkg::SPEED_W-1:0] rand_speed();
    logic [pec_pkg::SPEED_W-1:0] sp;
    sp = $urandom_range(0, {pec_pkg::SPEED_W{1'b1}});
    if (sp == {1'b1, {(pec_pkg::SPEED_W - 1){1'b0}}}) sp = '0;
    return sp;
  endfunction

  function automatic logic [pec_pkg::STAMP_W-1:0] pick_stamp();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return '0;
    if (roll < 8) return stamp_now - pec_pkg::STAMP_W'($urandom_range(0, 5000000));
    if (roll < 10) return pec_pkg::STAMP_W'({$urandom(), $urandom()});
    return stamp_now + pec_pkg::STAMP_W'($urandom_range(1, 10000000));
  endfunction

  task automatic send_shaped(shape_e shape);
    logic signed [pec_pkg::ANG_W-1:0] ti;
    logic signed [pec_pkg::ANG_W-1:0] ra;
    case (shape)
      SHAPE_QUIET: begin
        ti = angle_below(trig_tilt);
        ra = angle_below(trig_rate);
      end
      SHAPE_KICK: begin
        if ($urandom_range(0, 1)) begin
          ti = angle_above(trig_tilt);
          ra = $urandom();
        end else begin
          ti = $urandom();
          ra = angle_above(trig_rate);
        end
      end
      SHAPE_CALM: begin
        ti = angle_calm(calm_tilt);
        ra = angle_calm(calm_rate);
      end
      default: begin
        ti = $urandom();
        ra = $urandom();
      end
    endcase
    send(pick_stamp(), ti, ra, rand_speed(), $urandom());
  endtask

  // Three calm samples more than half the settle time apart can end an episode.
  task automatic close_episode();
    repeat (3) begin
      send(stamp_now + pec_pkg::STAMP_W'(settle_ns / 2 + 1), angle_calm(calm_tilt),
           angle_calm(calm_rate), rand_speed(), $urandom());
    end
  endtask

  task automatic run_episode(int unsigned fill_len, int unsigned rec_len);
    int unsigned roll;
    repeat (fill_len) send_shaped(($urandom_range(0, 9) == 0) ? SHAPE_NOISE : SHAPE_QUIET);
    send_shaped(SHAPE_KICK);
    repeat (rec_len) begin
      roll = $urandom_range(0, 19);
      send_shaped((roll < 12) ? SHAPE_CALM : (roll < 17) ? SHAPE_QUIET : SHAPE_NOISE);
    end
    close_episode();
  endtask

  initial begin
    int unsigned start_count;
    sample_if.valid = 1'b0;
    sample_if.stamp_ns = '0;
    sample_if.tilt = '0;
    sample_if.tilt_rate = '0;
    sample_if.speed = '0;
    sample_if.drive = '0;
    reg_if.valid = 1'b0;
    reg_if.index = '0;
    reg_if.data = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset thresholds.
    send(63'd0, 32'sd0, 32'sd0, 24'sh7FFFFF, 32'sh80000000);
    send(63'd0, 32'sd655, -32'sd655, -24'sd8388607, 32'sh7FFFFFFF);
    send(63'd1000, 32'sd1966, -32'sd1966, 24'sd8388607, 32'sd0);
    send(63'd2000, -32'sd1966, 32'sd3277, 24'sd8388607, -32'sd1);
    send(63'd1500, 32'sd0, -32'sd3277, 24'sd100, 32'sd12345);
    send(63'd2500, 32'sd1967, 32'sd0, -24'sd50, 32'sd1);
    send(63'd3000, 32'sd1966, 32'sd0, 24'sd0, 32'sd0);
    send(63'd3500, 32'sd654, -32'sd3276, 24'sd5, 32'sd0);
    send(63'd3400, 32'sd654, 32'sd3276, 24'sd5, 32'sd0);
    send(63'd500003500, -32'sd654, 32'sd0, 24'sd5, 32'sd0);
    send(63'h4000_0000_0000_0000, 32'sd0, 32'sd0, 24'sd8388607, 32'sd0);
    send(63'd1, 32'sd0, 32'sd0, 24'sd8388607, 32'sd0);
    send(63'h7FFF_FFFF_FFFF_FFFF, 32'sd0, 32'sd0, -24'sd8388607, 32'sd0);
    send(63'd1, 32'sd0, 32'sd0, 24'sd8388607, 32'sd0);
    send(63'd2, 32'sd0, 32'sh80000000, 24'sd7, 32'sd3);
    send(63'd3, 32'sh80000000, 32'sd0, -24'sd7, 32'sd4);
    send(63'd10, 32'sd0, 32'sd0, 24'sd1, 32'sd5);
    send(63'd500000010, 32'sd0, 32'sd0, 24'sd1, 32'sd6);
    send(63'd500000020, 32'sd0, 32'sd3278, -24'sd1, 32'sd7);
    close_episode();
    settle_down();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: apply_settings('1, '1, '1, '1, '1, 1'b1);
        1: apply_settings('0, '0, '0, '0, '0, 1'b1);
        2: apply_settings($urandom_range(0, 200000), $urandom_range(0, 200000),
                          $urandom_range(1, 200000), $urandom_range(1, 200000),
                          $urandom_range(0, 20000000), 1'b0);
        3: apply_settings($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), 1'b0);
        default: apply_settings(pec_pkg::TILT_TRIGGER_RST, pec_pkg::RATE_TRIGGER_RST,
                                pec_pkg::TILT_STABLE_RST, pec_pkg::RATE_STABLE_RST,
                                $urandom_range(0, 30000000), 1'b0);
      endcase
      if (recording) close_episode();
      start_count = items_sent;
      if (ph == 2) run_episode(pec_pkg::DEPTH + 2, 2);
      while (items_sent - start_count < 6) begin
        run_episode($urandom_range(0, 4), $urandom_range(0, 3));
      end
      settle_down();
    end

    $display("Sent %0d samples and %0d register writes under six threshold settings.",
             items_sent, reg_writes);
    $display("Checked %0d results over %0d episodes, ring wrap and saturation included.",
             checked, episodes);
    if (fail_count == 0 && pending == 0) begin
      $display("pretrigger_episode_capture_tb OK");
    end else begin
      $display("pretrigger_episode_capture_tb NOT OK");
    end
    $finish;
  end

endmodule
